FILE: rtl/rrip_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin identifier pool package
// Shared constants, codes and helper functions for the identifier pool.
// ----------------------------------------------------------------------------
`default_nettype none

package rrip_pkg;

  // Pool size and bitmap geometry.
  localparam int MAX_ID    = 65535;
  localparam int ID_W      = 16;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int MAP_WORDS = 1024;
  localparam int WORD_AW   = $clog2(MAP_WORDS);

  // Last bitmap word that holds a valid identifier, and its top valid bit.
  localparam int LAST_WORD_I = (MAX_ID - 1) / WORD_BITS;
  localparam int LAST_BIT    = (MAX_ID - 1) % WORD_BITS;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(LAST_WORD_I);
  localparam logic [WORD_BITS-1:0] LAST_WORD_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - LAST_BIT);

  // Word visits of a full search: every word once, plus the start word again.
  localparam int SCAN_WORDS = LAST_WORD_I + 1;
  localparam int VIS_W      = $clog2(SCAN_WORDS + 1);

  // Stream payload widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_INVALID   = 2'd2;
  localparam logic [1:0] STAT_UNUSED    = 2'd3;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_RESP
  } state_t;

  // Bits of a bitmap word that map to identifiers inside the pool.
  function automatic logic [WORD_BITS-1:0] word_valid_mask(input logic [WORD_AW-1:0] word);
    word_valid_mask = (word == LAST_WORD) ? LAST_WORD_MASK : {WORD_BITS{1'b1}};
  endfunction

  // True when an identifier lies inside 1..MAX_ID.
  function automatic logic id_valid(input logic [ID_W-1:0] id);
    id_valid = (id != '0) && (id <= ID_W'(MAX_ID));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/round_robin_id_pool_unit.sv
// ----------------------------------------------------------------------------
// Round-robin identifier pool
// Allocates, releases and queries identifiers held in a used-bitmap memory.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+---------------------------------------------------
//  s_*     | in        | tdata: req_id; tuser: kind
//  m_*     | out       | tdata: granted_id, status, id_in_use, used_count
//
//  Release, query and unknown operations go through the steps accept, memory
//  read and result. An allocate repeats the memory read for each further
//  bitmap word that the search reads, until one has a free identifier.
//  After reset a clearing pass writes all 1024 bitmap words, one per cycle,
//  and no item is accepted until it ends. A stalled result waits in the
//  output register; the next item is accepted meanwhile and holds in its
//  result step until the register is free.
//
`default_nettype none

module round_robin_id_pool_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [15:0] req_id
  input  wire logic [rrip_pkg::IN_DATA_W-1:0]     s_tdata,
  // [1:0] kind
  input  wire logic [rrip_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [15:0] granted_id, [17:16] status, [18] id_in_use, [34:19] used_count,
  // [39:35] zero
  output logic [rrip_pkg::OUT_DATA_W-1:0]         m_tdata
);

  localparam int WB = rrip_pkg::WORD_BITS;
  localparam int AW = rrip_pkg::WORD_AW;
  localparam int BW = rrip_pkg::BIT_W;
  localparam int IW = rrip_pkg::ID_W;
  localparam int VW = rrip_pkg::VIS_W;

  // Used-bitmap memory with a registered read.
  logic [WB-1:0] mem [rrip_pkg::MAP_WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WB-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [WB-1:0] mem_rdata;

  // Control and working registers.
  rrip_pkg::state_t state, state_next;
  logic [AW-1:0] clr_cnt;
  logic [1:0]    kind_q;
  logic [IW-1:0] id_q;
  logic [AW-1:0] word_q, word_next;
  logic [BW-1:0] bit_q;
  logic [VW-1:0] visits, visits_next;
  logic [IW-1:0] count_q, count_next;
  logic [IW-1:0] last_q, last_next;
  logic [IW-1:0] res_granted, res_granted_next;
  logic [1:0]    res_status, res_status_next;
  logic          res_inuse, res_inuse_next;
  logic          eval_done;
  logic          out_free;

  // Search and lookup helpers.
  logic [IW-1:0] start_pos;
  logic [IW-1:0] in_pos;
  logic [WB-1:0] free_bits;
  logic [WB-1:0] free_onehot;
  logic [BW-1:0] free_idx;
  logic [WB-1:0] id_onehot;
  logic          id_bit;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == rrip_pkg::ST_IDLE);

  // Search starts just after the last grant, wrapping past the top to the first id.
  assign start_pos = (last_q == IW'(rrip_pkg::MAX_ID)) ? '0 : last_q;
  assign in_pos    = s_tdata[IW-1:0] - IW'(1);

  // Free bits of the current word within the search window.
  always_comb begin
    free_bits = ~mem_rdata & rrip_pkg::word_valid_mask(word_q);
    if (visits == '0) begin
      free_bits = free_bits & ({WB{1'b1}} << bit_q);
    end
    if (visits == VW'(rrip_pkg::SCAN_WORDS)) begin
      free_bits = free_bits & ~({WB{1'b1}} << bit_q);
    end
  end

  // Lowest free bit and its index.
  assign free_onehot = free_bits & (~free_bits + WB'(1));
  always_comb begin
    free_idx = '0;
    for (int i = 0; i < WB; i++) begin
      if (free_onehot[i]) begin
        free_idx = free_idx | BW'(i);
      end
    end
  end

  assign id_onehot = WB'(1) << bit_q;
  assign id_bit    = mem_rdata[bit_q];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rrip_pkg::ST_CLEAR: begin
        if (clr_cnt == AW'(rrip_pkg::MAP_WORDS - 1)) begin
          state_next = rrip_pkg::ST_IDLE;
        end
      end
      rrip_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = rrip_pkg::ST_EVAL;
        end
      end
      rrip_pkg::ST_EVAL: begin
        if (eval_done) begin
          state_next = rrip_pkg::ST_RESP;
        end
      end
      rrip_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = rrip_pkg::ST_IDLE;
        end
      end
      default: state_next = rrip_pkg::ST_CLEAR;
    endcase
  end

  // Memory accesses and datapath next values.
  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = word_q;
    mem_wdata        = mem_rdata;
    mem_raddr        = word_q;
    word_next        = word_q;
    visits_next      = visits;
    count_next       = count_q;
    last_next        = last_q;
    res_granted_next = res_granted;
    res_status_next  = res_status;
    res_inuse_next   = res_inuse;
    eval_done        = 1'b0;
    unique case (state)
      rrip_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      rrip_pkg::ST_IDLE: begin
        if (s_tuser == rrip_pkg::KIND_ALLOC) begin
          mem_raddr = start_pos[IW-1 -: AW];
        end else begin
          mem_raddr = in_pos[IW-1 -: AW];
        end
        word_next   = mem_raddr;
        visits_next = '0;
      end
      rrip_pkg::ST_EVAL: begin
        res_granted_next = '0;
        res_status_next  = rrip_pkg::STAT_OK;
        res_inuse_next   = 1'b0;
        case (kind_q)
          rrip_pkg::KIND_ALLOC: begin
            if (count_q >= IW'(rrip_pkg::MAX_ID)) begin
              res_status_next = rrip_pkg::STAT_EXHAUSTED;
              eval_done       = 1'b1;
            end else if (free_bits != '0) begin
              mem_we           = 1'b1;
              mem_wdata        = mem_rdata | free_onehot;
              res_granted_next = {word_q, free_idx} + IW'(1);
              last_next        = {word_q, free_idx} + IW'(1);
              count_next       = count_q + IW'(1);
              eval_done        = 1'b1;
            end else if (visits == VW'(rrip_pkg::SCAN_WORDS)) begin
              res_status_next = rrip_pkg::STAT_EXHAUSTED;
              eval_done       = 1'b1;
            end else begin
              // Move on to the next word, wrapping to the first.
              word_next   = (word_q == rrip_pkg::LAST_WORD) ? '0 : word_q + AW'(1);
              mem_raddr   = word_next;
              visits_next = visits + VW'(1);
            end
          end
          rrip_pkg::KIND_RELEASE: begin
            eval_done = 1'b1;
            if (!rrip_pkg::id_valid(id_q)) begin
              res_status_next = rrip_pkg::STAT_INVALID;
            end else if (!id_bit) begin
              res_status_next = rrip_pkg::STAT_UNUSED;
            end else begin
              mem_we     = 1'b1;
              mem_wdata  = mem_rdata & ~id_onehot;
              count_next = count_q - IW'(1);
            end
          end
          rrip_pkg::KIND_QUERY: begin
            eval_done = 1'b1;
            if (!rrip_pkg::id_valid(id_q)) begin
              res_status_next = rrip_pkg::STAT_INVALID;
            end else begin
              res_inuse_next = id_bit;
            end
          end
          default: begin
            // Unknown operation: no change, plain ok result.
            eval_done = 1'b1;
          end
        endcase
      end
      rrip_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Bitmap memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rrip_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      count_q  <= '0;
      last_q   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count_q <= count_next;
      last_q  <= last_next;
      if (state == rrip_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == rrip_pkg::ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    word_q      <= word_next;
    visits      <= visits_next;
    res_granted <= res_granted_next;
    res_status  <= res_status_next;
    res_inuse   <= res_inuse_next;
    if (s_tvalid && s_tready) begin
      kind_q <= s_tuser;
      id_q   <= s_tdata[IW-1:0];
      if (s_tuser == rrip_pkg::KIND_ALLOC) begin
        bit_q <= start_pos[BW-1:0];
      end else begin
        bit_q <= in_pos[BW-1:0];
      end
    end
    if (state == rrip_pkg::ST_RESP && out_free) begin
      m_tdata <= {5'd0, count_q, res_inuse, res_status, res_granted};
    end
  end

`ifndef SYNTHESIS
  // The in-use count never exceeds the pool size.
  assert property (@(posedge clk) disable iff (rst)
    count_q <= IW'(rrip_pkg::MAX_ID))
    else $error("in-use count above pool size");

  // An allocation only ever marks a bit that was free.
  assert property (@(posedge clk) disable iff (rst)
    (state == rrip_pkg::ST_EVAL && mem_we && kind_q == rrip_pkg::KIND_ALLOC)
      |-> ((mem_rdata & free_onehot) == '0 && free_onehot != '0))
    else $error("allocation marked a used bit");

  // A successful release lowers the count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (state == rrip_pkg::ST_EVAL && mem_we && kind_q == rrip_pkg::KIND_RELEASE)
      |=> (count_q == $past(count_q) - IW'(1)))
    else $error("release did not decrement the count");
`endif

endmodule

`default_nettype wire
